FILE: rtl/stable_min_priority_queue_unit_macros.svh
// Assertion macros for the stable minimum priority queue.
// Standalone header; used by the top level only.
`ifndef STABLE_MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SMPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// next-cycle implication, disabled in reset
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

`endif

FILE: rtl/smpq_pkg.sv
// Shared codes and types for the stable minimum priority queue.
// No dependencies.
`timescale 1ns / 1ps

package smpq_pkg;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic sample;
        logic first;
    } pick_ctl_t;

endpackage

FILE: rtl/smpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module smpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/smpq_pick.sv
// Running oldest-minimum tracker fed by the RAM read stream.
// Depends on smpq_pkg.
`timescale 1ns / 1ps

module smpq_pick
    import smpq_pkg::*;
#(
    parameter int AW             = 6,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pick_ctl_t                 ctl,
    input  logic [AW-1:0]             idx,
    input  logic [PRIORITY_WIDTH-1:0] prio,
    input  logic [PAYLOAD_WIDTH-1:0]  payload,
    output logic [AW-1:0]             best_idx,
    output logic [PAYLOAD_WIDTH-1:0]  best_payload
);

    logic [AW-1:0]             best_idx_reg;
    logic [PRIORITY_WIDTH-1:0] best_prio_reg;
    logic [PAYLOAD_WIDTH-1:0]  best_payload_reg;
    logic                      take;

    // strict compare keeps the oldest of equal priorities
    assign take = ctl.sample && (ctl.first || (prio < best_prio_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_idx_reg <= '0;
        end
        else if (take)
        begin
            best_idx_reg <= idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_prio_reg    <= prio;
            best_payload_reg <= payload;
        end
    end

    assign best_idx     = best_idx_reg;
    assign best_payload = best_payload_reg;

endmodule

FILE: rtl/stable_min_priority_queue_unit.sv
// Stable minimum priority queue: top level, sequencer and result registers.
// Depends on smpq_pkg, smpq_ram, smpq_pick and the assertion macro header.
`timescale 1ns / 1ps
`include "stable_min_priority_queue_unit_macros.svh"

// Usage
//   Command channel: a beat is taken when start is high and busy is low.
//   action selects insert or extract; payload_in and priority_in matter on insert.
//   Result channel: done pulses for one cycle with payload_out, status,
//   occupancy and is_empty; the receiver cannot stall and must take it then.
//   Insert, full insert and empty extract: the result is registered and shows in
//   the next cycle; busy stays low, so a new beat may follow straight away.
//   Extract: busy is high while one pass reads every entry for the oldest
//   minimum and a second pass moves the younger entries down one place; both
//   go through the single read port of the entry RAM.
//   Reset empties the queue; RAM contents are not cleared and need no sweep.
//   Result registers are separate, so a result is shown while the next beat
//   is already accepted.
module stable_min_priority_queue_unit
    import smpq_pkg::*;
#(
    parameter int DEPTH          = 64,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  logic [PAYLOAD_WIDTH-1:0]    payload_in,
    input  logic [PRIORITY_WIDTH-1:0]   priority_in,
    output logic                        done,
    output logic [PAYLOAD_WIDTH-1:0]    payload_out,
    output logic [1:0]                  status,
    output logic [$clog2(DEPTH+1)-1:0]  occupancy,
    output logic                        is_empty
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = PAYLOAD_WIDTH + PRIORITY_WIDTH;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SDRAIN = 3'd2;
    localparam logic [2:0] S_PREP   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]         rd_idx_q_reg, rd_idx_q_next;
    logic                     done_reg, done_next;
    logic [PAYLOAD_WIDTH-1:0] payload_out_reg, payload_out_next;
    logic [1:0]               status_reg, status_next;
    logic [CNT_W-1:0]         occupancy_reg, occupancy_next;
    logic                     empty_reg, empty_next;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [EW-1:0]            wr_data;
    logic [AW-1:0]            rd_addr;
    logic [EW-1:0]            rd_data;
    logic [CNT_W-1:0]         shift_addr;
    logic [AW-1:0]            best_idx;
    logic [PAYLOAD_WIDTH-1:0] best_payload;
    pick_ctl_t                pick_ctl;

    smpq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pick_ctl.sample = rd_pend_reg && ((state_reg == S_SCAN) || (state_reg == S_SDRAIN));
    assign pick_ctl.first  = (rd_idx_q_reg == '0);

    smpq_pick #(
        .AW             (AW),
        .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_pick (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (pick_ctl),
        .idx          (rd_idx_q_reg[AW-1:0]),
        .prio         (rd_data[PRIORITY_WIDTH-1:0]),
        .payload      (rd_data[EW-1:PRIORITY_WIDTH]),
        .best_idx     (best_idx),
        .best_payload (best_payload)
    );

    assign shift_addr = rd_idx_q_reg - CNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        rd_pend_next     = 1'b0;
        rd_idx_q_next    = rd_idx_q_reg;
        done_next        = 1'b0;
        payload_out_next = payload_out_reg;
        status_next      = status_reg;
        occupancy_next   = occupancy_reg;
        empty_next       = empty_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[AW-1:0];
        wr_data          = {payload_in, priority_in};
        rd_addr          = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_INSERT)
                    begin
                        done_next        = 1'b1;
                        payload_out_next = '0;
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next    = ST_FULL;
                            occupancy_next = count_reg;
                            empty_next     = 1'b0;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                            status_next    = ST_OK;
                            occupancy_next = count_reg + CNT_W'(1);
                            empty_next     = 1'b0;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next        = 1'b1;
                        payload_out_next = '0;
                        status_next      = ST_EMPTY;
                        occupancy_next   = '0;
                        empty_next       = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_pend_next  = 1'b1;
                rd_idx_q_next = idx_reg;
                idx_next      = idx_reg + CNT_W'(1);
                if (idx_reg == count_reg - CNT_W'(1))
                begin
                    state_next = S_SDRAIN;
                end
            end
            S_SDRAIN:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                idx_next   = CNT_W'(best_idx) + CNT_W'(1);
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                // read entry i+1 while writing back the entry read in the previous cycle
                wr_en   = rd_pend_reg;
                wr_addr = shift_addr[AW-1:0];
                wr_data = rd_data;
                if (idx_reg < count_reg)
                begin
                    rd_pend_next  = 1'b1;
                    rd_idx_q_next = idx_reg;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                count_next       = count_reg - CNT_W'(1);
                done_next        = 1'b1;
                payload_out_next = best_payload;
                status_next      = ST_OK;
                occupancy_next   = count_reg - CNT_W'(1);
                empty_next       = (count_reg == CNT_W'(1));
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_q_reg    <= rd_idx_q_next;
        payload_out_reg <= payload_out_next;
        status_reg      <= status_next;
        occupancy_reg   <= occupancy_next;
        empty_reg       <= empty_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign payload_out = payload_out_reg;
    assign status      = status_reg;
    assign occupancy   = occupancy_reg;
    assign is_empty    = empty_reg;

    `SMPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SMPQ_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, !busy)
    `SMPQ_ASSERT_NEXT(a_beat_progress, clk, rst_n, start && !busy, done_reg || busy)
    `SMPQ_ASSERT_NOW(a_shift_in_range, clk, rst_n, wr_en && (state_reg == S_SHIFT), shift_addr < count_reg - CNT_W'(1))

endmodule
